/* design/assert_macros.svh */
// assertion macros used by the top-level rtl file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is active
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/ises_pkg.sv */
// types, codes and default sizes for the i2c status event sequencer
// no dependencies; imported by ises_ram and the top level
`timescale 1ns / 1ps

package ises_pkg;

    // default storage sizes
    localparam int RX_FIFO_DEPTH_DEF    = 16;
    localparam int MASTER_BUF_DEPTH_DEF = 64;
    localparam int SLAVE_TX_DEPTH_DEF   = 64;

    // field widths
    localparam int DATA_W     = 8;
    localparam int HOST_IDX_W = 6;
    localparam int COUNT_W    = 7;
    // host index widened so it covers any buffer depth up to 511
    localparam int HOST_EXT_W = 9;
    localparam int APB_AW     = 3;

    // register indexes (paddr[2])
    localparam logic REG_SLAVE_EN = 1'b0;

    // transaction modes
    localparam logic [2:0] MODE_BUS_EVENT = 3'd0;
    localparam logic [2:0] MODE_START     = 3'd1;
    localparam logic [2:0] MODE_WR_MB     = 3'd2;
    localparam logic [2:0] MODE_RD_MB     = 3'd3;
    localparam logic [2:0] MODE_WR_ST     = 3'd4;
    localparam logic [2:0] MODE_POP_FIFO  = 3'd5;

    // controller status codes
    localparam logic [7:0] SC_BUS_ERROR      = 8'h00;
    localparam logic [7:0] SC_START          = 8'h08;
    localparam logic [7:0] SC_RSTART         = 8'h10;
    localparam logic [7:0] SC_MT_SLA_ACK     = 8'h18;
    localparam logic [7:0] SC_MT_SLA_NACK    = 8'h20;
    localparam logic [7:0] SC_MT_DATA_ACK    = 8'h28;
    localparam logic [7:0] SC_MT_DATA_NACK   = 8'h30;
    localparam logic [7:0] SC_ARB_LOST       = 8'h38;
    localparam logic [7:0] SC_MR_SLA_ACK     = 8'h40;
    localparam logic [7:0] SC_MR_SLA_NACK    = 8'h48;
    localparam logic [7:0] SC_MR_DATA_ACK    = 8'h50;
    localparam logic [7:0] SC_MR_DATA_NACK   = 8'h58;
    localparam logic [7:0] SC_SR_DATA_ACK    = 8'h80;
    localparam logic [7:0] SC_SR_GC_DATA_ACK = 8'h90;
    localparam logic [7:0] SC_ST_SLA_ACK     = 8'hA8;
    localparam logic [7:0] SC_ST_ARB_SLA_ACK = 8'hB0;
    localparam logic [7:0] SC_ST_DATA_ACK    = 8'hB8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BUSY  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_SET  = 2'd1,
        ACT_CLR  = 2'd2
    } t_act;

    // per-cycle enables of one buffer
    typedef struct packed {
        logic wr;
        logic rd;
    } t_ram_en;

endpackage

/* design/ises_ram.sv */
// byte buffer with one write port and one registered read port
// read sees a write to the same address in the same cycle; uses ises_pkg
`timescale 1ns / 1ps

module ises_ram
    import ises_pkg::*;
#(
    parameter int   DEPTH = MASTER_BUF_DEPTH_DEF,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  t_ram_en           i_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_en.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read with same-cycle write forwarding
    always_ff @(posedge i_clk) begin
        if (i_en.rd) begin
            if (i_en.wr && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/i2c_status_event_sequencer_unit.sv */
// top level of the i2c status event sequencer: decode, counters, fifo pointers
// depends on ises_pkg, ises_ram and assert_macros.svh
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   in      | input     | i_in_valid / o_in_stall | mode, status code, bytes, index
//   out     | output    | o_out_valid / i_out_stall | actions, status, counts, read byte
//   cfg     | input     | psel penable pwrite pready | slave_enabled at byte address 0
//
// one transaction per cycle unless stalled; each passes the input and result registers
// buffer reads are issued at acceptance from next-state pointers; writes come at decode
// synchronous active-low reset clears counters, pointers, status and slave_enabled
// a stalled result holds the result register; the input register then fills and stalls
`timescale 1ns / 1ps

module i2c_status_event_sequencer_unit
    import ises_pkg::*;
#(
    parameter int RX_FIFO_DEPTH    = RX_FIFO_DEPTH_DEF,
    parameter int MASTER_BUF_DEPTH = MASTER_BUF_DEPTH_DEF,
    parameter int SLAVE_TX_DEPTH   = SLAVE_TX_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_mode,
    input  logic [7:0]            i_status_code,
    input  logic [DATA_W-1:0]     i_bus_data,
    input  logic [HOST_IDX_W-1:0] i_host_index,
    input  logic [DATA_W-1:0]     i_host_byte,
    input  logic [7:0]            i_target_address_rw,
    input  logic [COUNT_W-1:0]    i_transfer_length,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DATA_W-1:0]     o_tx_byte,
    output logic                  o_tx_byte_valid,
    output logic [1:0]            o_start_action,
    output logic                  o_stop_set,
    output logic [1:0]            o_ack_action,
    output logic [1:0]            o_master_status,
    output logic [COUNT_W-1:0]    o_bytes_left,
    output logic [DATA_W-1:0]     o_host_read_byte,
    output logic                  o_fifo_empty,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int MB_AW = (MASTER_BUF_DEPTH > 1) ? $clog2(MASTER_BUF_DEPTH) : 1;
    localparam int ST_AW = (SLAVE_TX_DEPTH > 1) ? $clog2(SLAVE_TX_DEPTH) : 1;
    localparam int RX_AW = $clog2(RX_FIFO_DEPTH);

    // handshake
    logic in_accept;
    logic advance;
    logic s_fire;

    // input register
    logic                  r_in_valid;
    logic [2:0]            r_in_mode;
    logic [7:0]            r_in_code;
    logic [DATA_W-1:0]     r_in_bus;
    logic [HOST_IDX_W-1:0] r_in_hidx;
    logic [DATA_W-1:0]     r_in_hbyte;
    logic [7:0]            r_in_taddr;
    logic [COUNT_W-1:0]    r_in_tlen;

    // sequencer state
    logic                  r_slave_en;
    t_status               r_status, n_status;
    logic [7:0]            r_addr, n_addr;
    logic [MB_AW-1:0]      r_mi, n_mi;
    logic [COUNT_W-1:0]    r_send, n_send;
    logic [COUNT_W-1:0]    r_rem, n_rem;
    logic [ST_AW-1:0]      r_sti, n_sti;
    logic [RX_AW-1:0]      r_head, n_head;
    logic [RX_AW-1:0]      r_tail, n_tail;

    // result register
    logic                  r_out_valid;
    logic [DATA_W-1:0]     r_out_tx;
    logic                  r_out_txv;
    t_act                  r_out_start;
    logic                  r_out_stop;
    t_act                  r_out_ack;
    t_status               r_out_status;
    logic [COUNT_W-1:0]    r_out_rem;
    logic [DATA_W-1:0]     r_out_hread;
    logic                  r_out_empty;

    // decoded result
    logic [DATA_W-1:0]     d_tx;
    logic                  d_txv;
    t_act                  d_start;
    logic                  d_stop;
    t_act                  d_ack;
    logic [DATA_W-1:0]     d_hread;

    // helper values
    t_act                  w_ack_cfg;
    logic [COUNT_W-1:0]    w_send_sel;
    logic [COUNT_W-1:0]    w_send_inc;
    logic [COUNT_W-1:0]    w_rem_dec;
    logic [MB_AW:0]        w_mi_inc;
    logic [MB_AW-1:0]      w_mi_next;
    logic [ST_AW-1:0]      w_sti_base;
    logic [ST_AW:0]        w_sti_inc;
    logic [ST_AW-1:0]      w_sti_next;
    logic [RX_AW:0]        w_tail_inc;
    logic [RX_AW-1:0]      w_tail_next;
    logic [RX_AW:0]        w_head_inc;
    logic [RX_AW-1:0]      w_head_next;
    logic [HOST_EXT_W-1:0] w_hidx_r;
    logic [HOST_EXT_W-1:0] w_hidx_i;
    logic                  w_hidx_mb_ok;
    logic                  w_hidx_st_ok;

    // buffer ports
    t_ram_en               mb_en, st_en, rx_en;
    logic                  mb_wr, st_wr, rx_wr;
    logic [MB_AW-1:0]      mb_wa, mb_ra;
    logic [DATA_W-1:0]     mb_wd, mb_rd;
    logic [ST_AW-1:0]      st_ra;
    logic [DATA_W-1:0]     st_rd;
    logic [RX_AW-1:0]      rx_rd_addr;
    logic [DATA_W-1:0]     rx_rd;

    // handshake: the input register moves on whenever the result register can take it
    assign advance    = !r_out_valid || !i_out_stall;
    assign s_fire     = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLAVE_EN) ? {31'd0, r_slave_en} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_en <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SLAVE_EN)) begin
            r_slave_en <= pwdata[0];
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_mode  <= i_mode;
            r_in_code  <= i_status_code;
            r_in_bus   <= i_bus_data;
            r_in_hidx  <= i_host_index;
            r_in_hbyte <= i_host_byte;
            r_in_taddr <= i_target_address_rw;
            r_in_tlen  <= i_transfer_length;
        end
    end

    // counter and pointer arithmetic
    assign w_ack_cfg  = r_slave_en ? ACT_SET : ACT_CLR;
    assign w_send_sel = (r_in_code == SC_MT_SLA_ACK) ? r_rem : r_send;
    assign w_send_inc = (r_send == COUNT_MAX) ? COUNT_MAX : r_send + 1'b1;
    assign w_rem_dec  = (r_rem != '0) ? r_rem - 1'b1 : '0;

    assign w_mi_inc  = {1'b0, r_mi} + 1'b1;
    assign w_mi_next = (w_mi_inc >= (MB_AW + 1)'(MASTER_BUF_DEPTH)) ? '0 : w_mi_inc[MB_AW-1:0];

    assign w_sti_base = (r_in_code == SC_ST_DATA_ACK) ? r_sti : '0;
    assign w_sti_inc  = {1'b0, w_sti_base} + 1'b1;
    assign w_sti_next = (w_sti_inc >= (ST_AW + 1)'(SLAVE_TX_DEPTH)) ? '0 : w_sti_inc[ST_AW-1:0];

    assign w_tail_inc  = {1'b0, r_tail} + 1'b1;
    assign w_tail_next = (w_tail_inc >= (RX_AW + 1)'(RX_FIFO_DEPTH)) ? '0
                                                                     : w_tail_inc[RX_AW-1:0];
    assign w_head_inc  = {1'b0, r_head} + 1'b1;
    assign w_head_next = (w_head_inc >= (RX_AW + 1)'(RX_FIFO_DEPTH)) ? '0
                                                                     : w_head_inc[RX_AW-1:0];

    assign w_hidx_r     = HOST_EXT_W'(r_in_hidx);
    assign w_hidx_i     = HOST_EXT_W'(i_host_index);
    assign w_hidx_mb_ok = w_hidx_r < HOST_EXT_W'(MASTER_BUF_DEPTH);
    assign w_hidx_st_ok = w_hidx_r < HOST_EXT_W'(SLAVE_TX_DEPTH);

    // status event decode: next state, actions and buffer writes
    always_comb begin
        n_status = r_status;
        n_addr   = r_addr;
        n_mi     = r_mi;
        n_send   = r_send;
        n_rem    = r_rem;
        n_sti    = r_sti;
        n_head   = r_head;
        n_tail   = r_tail;
        d_tx     = '0;
        d_txv    = 1'b0;
        d_start  = ACT_NONE;
        d_stop   = 1'b0;
        d_ack    = ACT_NONE;
        d_hread  = '0;
        mb_wr    = 1'b0;
        mb_wa    = r_mi;
        mb_wd    = r_in_bus;
        st_wr    = 1'b0;
        rx_wr    = 1'b0;
        if (s_fire) begin
            case (r_in_mode)
                MODE_BUS_EVENT: begin
                    case (r_in_code)
                        SC_BUS_ERROR: begin
                            n_status = ST_ERROR;
                            d_start  = ACT_CLR;
                            d_stop   = 1'b1;
                            d_ack    = w_ack_cfg;
                        end
                        SC_START, SC_RSTART: begin
                            n_mi  = '0;
                            d_tx  = r_addr;
                            d_txv = 1'b1;
                        end
                        SC_MT_SLA_ACK, SC_MT_DATA_ACK: begin
                            d_start = ACT_CLR;
                            if (w_send_sel != '0) begin
                                n_send = w_send_sel - 1'b1;
                                d_tx   = mb_rd;
                                d_txv  = 1'b1;
                                n_mi   = w_mi_next;
                            end else begin
                                n_send   = w_send_sel;
                                n_status = ST_IDLE;
                                n_rem    = '0;
                                d_stop   = 1'b1;
                            end
                        end
                        SC_MT_DATA_NACK, SC_MT_SLA_NACK: begin
                            if (r_in_code == SC_MT_DATA_NACK) begin
                                n_rem = w_send_inc;
                            end
                            n_status = ST_IDLE;
                            d_start  = ACT_CLR;
                            d_stop   = 1'b1;
                        end
                        SC_ARB_LOST: begin
                            d_start = ACT_SET;
                        end
                        SC_MR_DATA_ACK, SC_MR_SLA_ACK: begin
                            if (r_in_code == SC_MR_DATA_ACK) begin
                                mb_wr = 1'b1;
                                n_mi  = w_mi_next;
                            end
                            n_rem   = w_rem_dec;
                            d_ack   = (w_rem_dec != '0) ? ACT_SET : ACT_CLR;
                            d_start = ACT_CLR;
                        end
                        SC_MR_DATA_NACK, SC_MR_SLA_NACK: begin
                            mb_wr    = (r_in_code == SC_MR_DATA_NACK);
                            d_ack    = w_ack_cfg;
                            n_status = ST_IDLE;
                            d_start  = ACT_CLR;
                            d_stop   = 1'b1;
                        end
                        SC_SR_DATA_ACK, SC_SR_GC_DATA_ACK: begin
                            // a full fifo keeps overwriting its spare slot
                            rx_wr = 1'b1;
                            if (w_tail_next != r_head) begin
                                n_tail = w_tail_next;
                            end
                        end
                        SC_ST_SLA_ACK, SC_ST_ARB_SLA_ACK, SC_ST_DATA_ACK: begin
                            d_tx  = st_rd;
                            d_txv = 1'b1;
                            n_sti = w_sti_next;
                        end
                        default: begin
                        end
                    endcase
                end
                MODE_START: begin
                    n_addr   = r_in_taddr;
                    n_rem    = r_in_tlen;
                    n_status = ST_BUSY;
                    d_start  = ACT_SET;
                end
                MODE_WR_MB: begin
                    mb_wr = w_hidx_mb_ok;
                    mb_wa = w_hidx_r[MB_AW-1:0];
                    mb_wd = r_in_hbyte;
                end
                MODE_RD_MB: begin
                    if (w_hidx_mb_ok) begin
                        d_hread = mb_rd;
                    end
                end
                MODE_WR_ST: begin
                    st_wr = w_hidx_st_ok;
                end
                MODE_POP_FIFO: begin
                    if (r_head != r_tail) begin
                        d_hread = rx_rd;
                        n_head  = w_head_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // read addresses follow the state the accepted transaction will see
    assign mb_ra      = (i_mode == MODE_RD_MB) ? w_hidx_i[MB_AW-1:0] : n_mi;
    assign st_ra      = (i_status_code == SC_ST_DATA_ACK) ? n_sti : '0;
    assign rx_rd_addr = n_head;

    assign mb_en = '{wr: mb_wr, rd: in_accept};
    assign st_en = '{wr: st_wr, rd: in_accept};
    assign rx_en = '{wr: rx_wr, rd: in_accept};

    // master data buffer
    ises_ram #(
        .DEPTH (MASTER_BUF_DEPTH)
    ) u_master_buf (
        .i_clk     (i_clk),
        .i_en      (mb_en),
        .i_wr_addr (mb_wa),
        .i_wr_data (mb_wd),
        .i_rd_addr (mb_ra),
        .o_rd_data (mb_rd)
    );

    // slave transmit buffer
    ises_ram #(
        .DEPTH (SLAVE_TX_DEPTH)
    ) u_slave_tx_buf (
        .i_clk     (i_clk),
        .i_en      (st_en),
        .i_wr_addr (w_hidx_r[ST_AW-1:0]),
        .i_wr_data (r_in_hbyte),
        .i_rd_addr (st_ra),
        .o_rd_data (st_rd)
    );

    // slave receive fifo storage
    ises_ram #(
        .DEPTH (RX_FIFO_DEPTH)
    ) u_rx_fifo (
        .i_clk     (i_clk),
        .i_en      (rx_en),
        .i_wr_addr (r_tail),
        .i_wr_data (r_in_bus),
        .i_rd_addr (rx_rd_addr),
        .o_rd_data (rx_rd)
    );

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_IDLE;
            r_addr   <= '0;
            r_mi     <= '0;
            r_send   <= '0;
            r_rem    <= '0;
            r_sti    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
        end else begin
            r_status <= n_status;
            r_addr   <= n_addr;
            r_mi     <= n_mi;
            r_send   <= n_send;
            r_rem    <= n_rem;
            r_sti    <= n_sti;
            r_head   <= n_head;
            r_tail   <= n_tail;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_tx     <= d_tx;
            r_out_txv    <= d_txv;
            r_out_start  <= d_start;
            r_out_stop   <= d_stop;
            r_out_ack    <= d_ack;
            r_out_status <= n_status;
            r_out_rem    <= n_rem;
            r_out_hread  <= d_hread;
            r_out_empty  <= (n_head == n_tail);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_tx_byte        = r_out_tx;
    assign o_tx_byte_valid  = r_out_txv;
    assign o_start_action   = r_out_start;
    assign o_stop_set       = r_out_stop;
    assign o_ack_action     = r_out_ack;
    assign o_master_status  = r_out_status;
    assign o_bytes_left     = r_out_rem;
    assign o_host_read_byte = r_out_hread;
    assign o_fifo_empty     = r_out_empty;

    // checks
`include "assert_macros.svh"

    `ASSERT_CLK(a_busy_from_start, i_clk, i_rst_n, (r_status != ST_BUSY) ##1 (r_status == ST_BUSY) |-> $past(s_fire && (r_in_mode == MODE_START)), "busy entered without a start transaction")
    `ASSERT_CLK(a_result_from_fire, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(s_fire), "result raised without a decoded transaction")
    `ASSERT_CLK(a_tail_moves_on_fire, i_clk, i_rst_n, !$stable(r_tail) |-> $past(s_fire && (r_in_mode == MODE_BUS_EVENT)), "fifo tail moved outside a bus event")

endmodule
